FILE: design/p300rc_pkg.sv
// ----------------------------------------------------------------------------
// p300rc_pkg
// Shared widths, register indexes and request/result types of the
// row/column speller classifier.
// ----------------------------------------------------------------------------
package p300rc_pkg;

   localparam int CHOICE_BITS    = 5;
   localparam int MAX_CHOICES    = 32;
   localparam int SEQ_BITS       = 4;
   localparam int MAX_SEQUENCES  = 16;
   localparam int SCORE_BITS     = 32;
   localparam int SUM_BITS       = SCORE_BITS + 4;
   localparam int CODE_BITS      = 6;
   localparam int DIM_BITS       = 5;
   localparam int CHAR_BITS      = 8;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_COLS = 1'd1;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 5'd6;
   localparam logic [DIM_BITS-1:0] DIM_MIN   = 5'd2;

   typedef struct packed {
      logic [CHOICE_BITS-1:0]       choice_index;
      logic signed [SCORE_BITS-1:0] score;
      logic                         first_sequence;
      logic                         last_choice;
      logic [SEQ_BITS-1:0]          sequence_index;
      logic [CODE_BITS-1:0]         target_col_code;
      logic [CODE_BITS-1:0]         target_row_code;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]  pred_col_code;
      logic [CODE_BITS-1:0]  pred_row_code;
      logic [CHAR_BITS-1:0]  char_index;
      logic                  hit;
      logic [COUNT_BITS-1:0] hits_so_far;
   } rsp_type;

   // Winning codes of one sequence, handed from the tracker to the result stage.
   typedef struct packed {
      logic [CODE_BITS-1:0] pred_col_code;
      logic [CODE_BITS-1:0] pred_row_code;
      logic [SEQ_BITS-1:0]  sequence_index;
      logic [CODE_BITS-1:0] target_col_code;
      logic [CODE_BITS-1:0] target_row_code;
   } pick_type;

   // A matrix dimension below two counts as zero.
   function automatic logic [DIM_BITS-1:0] effective_dim(input logic [DIM_BITS-1:0] dim);
      return (dim < DIM_MIN) ? '0 : dim;
   endfunction

endpackage

FILE: design/p300_row_column_speller_classifier.sv
// ----------------------------------------------------------------------------
// p300_row_column_speller_classifier
// Streaming row/column speller classifier with per-choice score sums.
// ----------------------------------------------------------------------------
// One request carries the classifier score of one stimulus choice, column
// choices first and then row choices. Each choice keeps a saturating sum over
// the sequences of a letter; first_sequence restarts it. A request with
// last_choice set yields one result on the rsp_ channel with the predicted
// codes, the character index, the hit flag and the hit count of its sequence
// index; other requests yield nothing.
// The csr_ channel writes num_rows (index 0) and num_cols (index 1); it is
// always ready and should be used only while no request is in flight.
// A request passes an input register, the sum and argmax stage and the result
// register, in that order, before its result is shown. One request is taken
// every cycle while the receiver does not stall; the sum update and argmax
// compare of the tracker stage set the cycle time. When the receiver stalls,
// the three stages fill up before req_ready drops, and requests without a
// result keep flowing as long as the tracker stage is free.
// Reset clears the pipeline, the argmax trackers and the hit counters and
// sets both dimensions to six; choice sums are not cleared.
// ----------------------------------------------------------------------------
module p300_row_column_speller_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  p300rc_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output p300rc_pkg::rsp_type                    rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [p300rc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [p300rc_pkg::DIM_BITS-1:0]        csr_wdata
);
   import p300rc_pkg::*;

   logic [DIM_BITS-1:0] num_rows_ff;
   logic [DIM_BITS-1:0] num_cols_ff;
   logic [DIM_BITS-1:0] rows_eff;
   logic [DIM_BITS-1:0] cols_eff;

   logic     v1_ff, v1_in;
   req_type  item_ff;
   logic     v2_ff, v2_in;
   pick_type pick_ff;
   pick_type pick;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff;
   rsp_type  result;

   logic req_accept;
   logic ready2;
   logic ready3;
   logic consume1;
   logic consume2;

   assign csr_ready = 1'b1;
   assign rows_eff  = effective_dim(num_rows_ff);
   assign cols_eff  = effective_dim(num_cols_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= DIM_RESET;
         num_cols_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            CSR_NUM_COLS: num_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A request without a result leaves the tracker stage at once; a final
   // one needs room in the stage behind it.
   always_comb begin
      ready3       = !rsp_valid_ff || rsp_ready;
      consume2     = v2_ff && ready3;
      ready2       = !v2_ff || ready3;
      consume1     = v1_ff && (!item_ff.last_choice || ready2);
      req_ready    = !v1_ff || consume1;
      req_accept   = req_valid && req_ready;
      v1_in        = req_accept || (v1_ff && !consume1);
      v2_in        = (consume1 && item_ff.last_choice) || (v2_ff && !consume2);
      rsp_valid_in = consume2 || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (consume1 && item_ff.last_choice) begin
         pick_ff <= pick;
      end
      if (consume2) begin
         rsp_data_ff <= result;
      end
   end

   p300rc_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .take     (consume1),
      .item     (item_ff),
      .rows_eff (rows_eff),
      .cols_eff (cols_eff),
      .pick     (pick)
   );

   p300rc_result u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (consume2),
      .pick     (pick_ff),
      .cols_eff (cols_eff),
      .result   (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A hit always leaves a non-zero count behind it.
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit |-> rsp_data_ff.hits_so_far != '0)
      else $error("hit reported with a zero hit count");

   // A final request leaving the tracker stage is held for the result stage.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      consume1 && item_ff.last_choice |=> v2_ff)
      else $error("final request lost between tracker and result stage");

   // A result loaded into the output register is offered next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      consume2 |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // Back-pressure on requests only arises when the input, pick and result registers are all full and rsp_ready is low.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && rsp_valid_ff && !rsp_ready)
      else $error("request refused with room in the pipeline");

endmodule

FILE: design/p300rc_tracker.sv
// ----------------------------------------------------------------------------
// p300rc_tracker
// Per-choice score sums and the running column and row argmax of a sequence.
// ----------------------------------------------------------------------------
module p300rc_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  p300rc_pkg::req_type              item,
   input  logic [p300rc_pkg::DIM_BITS-1:0]  rows_eff,
   input  logic [p300rc_pkg::DIM_BITS-1:0]  cols_eff,
   output p300rc_pkg::pick_type             pick
);
   import p300rc_pkg::*;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   logic signed [SUM_BITS-1:0] sums_ff [MAX_CHOICES];

   logic signed [SUM_BITS-1:0] best_col_sum_ff, best_col_sum_in;
   logic signed [SUM_BITS-1:0] best_row_sum_ff, best_row_sum_in;
   logic [CODE_BITS-1:0]       best_col_code_ff, best_col_code_in;
   logic [CODE_BITS-1:0]       best_row_code_ff, best_row_code_in;
   logic                       col_seen_ff, col_seen_in;
   logic                       row_seen_ff, row_seen_in;

   logic signed [SUM_BITS-1:0] old_sum;
   logic signed [SUM_BITS-1:0] score_ext;
   logic [SUM_BITS:0]          raw_sum;
   logic signed [SUM_BITS-1:0] sat_sum;
   logic signed [SUM_BITS-1:0] new_sum;
   logic [CODE_BITS-1:0]       code;
   logic                       is_col;
   logic                       col_win;
   logic                       row_win;
   logic signed [SUM_BITS-1:0] col_sum_up;
   logic signed [SUM_BITS-1:0] row_sum_up;
   logic [CODE_BITS-1:0]       col_code_up;
   logic [CODE_BITS-1:0]       row_code_up;
   logic                       col_seen_up;
   logic                       row_seen_up;

   always_comb begin
      old_sum   = sums_ff[item.choice_index];
      score_ext = {{(SUM_BITS-SCORE_BITS){item.score[SCORE_BITS-1]}}, item.score};
      raw_sum   = {old_sum[SUM_BITS-1], old_sum} + {score_ext[SUM_BITS-1], score_ext};

      // The extra top bit disagrees with the sign bit only on overflow.
      if (raw_sum[SUM_BITS] != raw_sum[SUM_BITS-1]) begin
         sat_sum = raw_sum[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_sum = raw_sum[SUM_BITS-1:0];
      end
      new_sum = item.first_sequence ? score_ext : sat_sum;

      // With no columns every choice is a row, and its code moves up by one.
      code = CODE_BITS'(item.choice_index) + CODE_BITS'(1)
           + ((cols_eff == '0) ? CODE_BITS'(1) : CODE_BITS'(0));
      is_col  = item.choice_index < cols_eff;
      col_win = is_col && (!col_seen_ff || new_sum > best_col_sum_ff);
      row_win = !is_col && (!row_seen_ff || new_sum > best_row_sum_ff);

      col_sum_up  = col_win ? new_sum : best_col_sum_ff;
      row_sum_up  = row_win ? new_sum : best_row_sum_ff;
      col_code_up = col_win ? code : best_col_code_ff;
      row_code_up = row_win ? code : best_row_code_ff;
      col_seen_up = col_seen_ff | col_win;
      row_seen_up = row_seen_ff | row_win;

      if (cols_eff == '0) begin
         pick.pred_col_code = CODE_BITS'(1);
      end else begin
         pick.pred_col_code = col_seen_up ? col_code_up : '0;
      end
      if (rows_eff == '0) begin
         pick.pred_row_code = CODE_BITS'(cols_eff) + CODE_BITS'(1);
      end else begin
         pick.pred_row_code = row_seen_up ? row_code_up : '0;
      end
      pick.sequence_index  = item.sequence_index;
      pick.target_col_code = item.target_col_code;
      pick.target_row_code = item.target_row_code;

      // The trackers start afresh after the last choice of a sequence.
      if (item.last_choice) begin
         best_col_sum_in  = '0;
         best_row_sum_in  = '0;
         best_col_code_in = '0;
         best_row_code_in = '0;
         col_seen_in      = 1'b0;
         row_seen_in      = 1'b0;
      end else begin
         best_col_sum_in  = col_sum_up;
         best_row_sum_in  = row_sum_up;
         best_col_code_in = col_code_up;
         best_row_code_in = row_code_up;
         col_seen_in      = col_seen_up;
         row_seen_in      = row_seen_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_col_sum_ff  <= '0;
         best_row_sum_ff  <= '0;
         best_col_code_ff <= '0;
         best_row_code_ff <= '0;
         col_seen_ff      <= 1'b0;
         row_seen_ff      <= 1'b0;
      end else if (take) begin
         best_col_sum_ff  <= best_col_sum_in;
         best_row_sum_ff  <= best_row_sum_in;
         best_col_code_ff <= best_col_code_in;
         best_row_code_ff <= best_row_code_in;
         col_seen_ff      <= col_seen_in;
         row_seen_ff      <= row_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sums_ff[item.choice_index] <= new_sum;
      end
   end

endmodule

FILE: design/p300rc_result.sv
// ----------------------------------------------------------------------------
// p300rc_result
// Hit check, character index and saturating hit counters per sequence.
// ----------------------------------------------------------------------------
module p300rc_result (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  p300rc_pkg::pick_type             pick,
   input  logic [p300rc_pkg::DIM_BITS-1:0]  cols_eff,
   output p300rc_pkg::rsp_type              result
);
   import p300rc_pkg::*;

   logic [COUNT_BITS-1:0] hit_counts_ff [MAX_SEQUENCES];

   logic                  hit;
   logic [COUNT_BITS-1:0] count_old;
   logic [COUNT_BITS-1:0] count_in;
   logic [CHAR_BITS-1:0]  ce;
   logic [CHAR_BITS-1:0]  row_off;
   logic [CHAR_BITS-1:0]  prod;

   always_comb begin
      hit       = (pick.pred_col_code == pick.target_col_code)
               && (pick.pred_row_code == pick.target_row_code);
      count_old = hit_counts_ff[pick.sequence_index];
      count_in  = (hit && count_old != '1) ? count_old + COUNT_BITS'(1) : count_old;

      // Character index wraps modulo 256, so 8-bit arithmetic is exact.
      ce      = (cols_eff == '0) ? CHAR_BITS'(1) : CHAR_BITS'(cols_eff);
      row_off = CHAR_BITS'(pick.pred_row_code) - CHAR_BITS'(1) - ce;
      prod    = ce * row_off;

      result.pred_col_code = pick.pred_col_code;
      result.pred_row_code = pick.pred_row_code;
      result.char_index    = prod + CHAR_BITS'(pick.pred_col_code) - CHAR_BITS'(1);
      result.hit           = hit;
      result.hits_so_far   = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SEQUENCES; i++) begin
            hit_counts_ff[i] <= '0;
         end
      end else if (load) begin
         hit_counts_ff[pick.sequence_index] <= count_in;
      end
   end

endmodule
